// ===== hw/rtl/iwe_pkg.sv =====
// ----------------------------------------------------------------------------
// iwe_pkg
// Shared types and constants for the instruction word encoder.
// ----------------------------------------------------------------------------
package iwe_pkg;

	localparam int unsigned MAX_WORDS = 4;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned WORD_W    = 32;

	typedef enum logic [5:0] {
		OP_MOV_RR  = 6'd0,
		OP_MOVZ    = 6'd1,
		OP_MOVK    = 6'd2,
		OP_MOV_IMM = 6'd3,
		OP_LDR     = 6'd4,
		OP_STR     = 6'd5,
		OP_ADD_RRR = 6'd6,
		OP_ADD_RRI = 6'd7,
		OP_SUB_RRR = 6'd8,
		OP_SUB_RRI = 6'd9,
		OP_MUL     = 6'd10,
		OP_SDIV    = 6'd11,
		OP_NEG     = 6'd12,
		OP_AND     = 6'd13,
		OP_ORR     = 6'd14,
		OP_EOR     = 6'd15,
		OP_MVN     = 6'd16,
		OP_LSL     = 6'd17,
		OP_LSR     = 6'd18,
		OP_CMP_RR  = 6'd19,
		OP_CMP_RI  = 6'd20,
		OP_TST     = 6'd21,
		OP_CSEL    = 6'd22,
		OP_CSET    = 6'd23,
		OP_STP     = 6'd24,
		OP_LDP     = 6'd25,
		OP_B       = 6'd26,
		OP_B_COND  = 6'd27,
		OP_BL      = 6'd28,
		OP_BR      = 6'd29,
		OP_BLR     = 6'd30,
		OP_RET     = 6'd31,
		OP_FMOV    = 6'd32,
		OP_FADD    = 6'd33,
		OP_FSUB    = 6'd34,
		OP_FMUL    = 6'd35,
		OP_FDIV    = 6'd36,
		OP_SCVTF   = 6'd37,
		OP_FCVTZS  = 6'd38,
		OP_ADRP    = 6'd39
	} op_t;

	localparam logic [4:0] REG_SP = 5'd31;

	localparam logic [31:0] ENC_ADD_IMM = 32'h9100_0000;
	localparam logic [31:0] ENC_MOV_REG = 32'hAA00_03E0;
	localparam logic [31:0] ENC_MOVZ    = 32'hD280_0000;
	localparam logic [31:0] ENC_MOVK    = 32'hF280_0000;
	localparam logic [31:0] ENC_LDR     = 32'hF940_0000;
	localparam logic [31:0] ENC_STR     = 32'hF900_0000;
	localparam logic [31:0] ENC_ADD_REG = 32'h8B00_0000;
	localparam logic [31:0] ENC_SUB_REG = 32'hCB00_0000;
	localparam logic [31:0] ENC_SUB_IMM = 32'hD100_0000;
	localparam logic [31:0] ENC_MUL     = 32'h9B00_7C00;
	localparam logic [31:0] ENC_SDIV    = 32'h9AC0_0C00;
	localparam logic [31:0] ENC_NEG     = 32'hCB00_03E0;
	localparam logic [31:0] ENC_AND     = 32'h8A00_0000;
	localparam logic [31:0] ENC_ORR     = 32'hAA00_0000;
	localparam logic [31:0] ENC_EOR     = 32'hCA00_0000;
	localparam logic [31:0] ENC_MVN     = 32'hAA20_03E0;
	localparam logic [31:0] ENC_UBFM    = 32'hD340_0000;
	localparam logic [31:0] ENC_LSR     = 32'hD340_FC00;
	localparam logic [31:0] ENC_CMP_REG = 32'hEB00_001F;
	localparam logic [31:0] ENC_CMP_IMM = 32'hF100_001F;
	localparam logic [31:0] ENC_TST     = 32'hEA00_001F;
	localparam logic [31:0] ENC_CSEL    = 32'h9A80_0000;
	localparam logic [31:0] ENC_CSET    = 32'h9A9F_07E0;
	localparam logic [31:0] ENC_STP     = 32'hA900_0000;
	localparam logic [31:0] ENC_LDP     = 32'hA940_0000;
	localparam logic [31:0] ENC_B       = 32'h1400_0000;
	localparam logic [31:0] ENC_B_COND  = 32'h5400_0000;
	localparam logic [31:0] ENC_BL      = 32'h9400_0000;
	localparam logic [31:0] ENC_BR      = 32'hD61F_0000;
	localparam logic [31:0] ENC_BLR     = 32'hD63F_0000;
	localparam logic [31:0] ENC_RET     = 32'hD65F_0000;
	localparam logic [31:0] ENC_FMOV    = 32'h1E60_4000;
	localparam logic [31:0] ENC_FADD    = 32'h1E60_2800;
	localparam logic [31:0] ENC_FSUB    = 32'h1E60_3800;
	localparam logic [31:0] ENC_FMUL    = 32'h1E60_0800;
	localparam logic [31:0] ENC_FDIV    = 32'h1E60_1800;
	localparam logic [31:0] ENC_SCVTF   = 32'h9E62_0000;
	localparam logic [31:0] ENC_FCVTZS  = 32'h9E78_0000;
	localparam logic [31:0] ENC_ADRP    = 32'h9000_0000;

	typedef struct packed {
		logic [5:0]         req_type;
		logic [4:0]         dest_reg;
		logic [4:0]         first_src_reg;
		logic [4:0]         second_src_reg;
		logic [3:0]         cond_code;
		logic [63:0]        imm_value;
		logic signed [31:0] byte_offset;
		logic [5:0]         shift_amount;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0]                 count;
		logic [MAX_WORDS-1:0][WORD_W-1:0] words;
	} enc_t;

endpackage

// ===== hw/rtl/instruction_word_encoder_unit.sv =====
// An accepted request is held in the input register and encoded into the output
// word buffer. One request per cycle for single-word operations while the output
//   is ready; a 64-bit immediate load holds the buffer until its 1 to 4 words leave.
// Requests that yield no word pass the input register and are dropped there.
// Reset (arst_n low) empties both stages; payload registers are not reset.
// ----------------------------------------------------------------------------
// instruction_word_encoder_unit
// Encodes operation requests into 32-bit A64 instruction word streams.
// ----------------------------------------------------------------------------
module instruction_word_encoder_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// dest_reg, first_src_reg, second_src_reg, cond_code, imm_value,
	// byte_offset, shift_amount, zero pad
	input  logic [127:0] s_axis_tdata,
	// req_type
	input  logic [5:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// instruction_word
	output logic [31:0]  m_axis_tdata,
	output logic         m_axis_tlast
);

	iwe_pkg::req_t req_s1;
	logic          valid_s1;
	iwe_pkg::enc_t enc;

	logic [iwe_pkg::MAX_WORDS-1:0][iwe_pkg::WORD_W-1:0] words_s2;
	logic [iwe_pkg::CNT_W-1:0]                          cnt_s2;

	logic s_take, m_take, s2_free, adv1, load_s2;

	assign m_axis_tvalid = cnt_s2 != '0;
	assign m_axis_tlast  = cnt_s2 == iwe_pkg::CNT_W'(1);
	assign m_axis_tdata  = words_s2[0];

	assign m_take  = m_axis_tvalid && m_axis_tready;
	assign s2_free = !m_axis_tvalid || (m_take && m_axis_tlast);
	assign adv1    = valid_s1 && (enc.count == '0 || s2_free);
	assign load_s2 = adv1 && enc.count != '0;
	assign s_axis_tready = !valid_s1 || adv1;
	assign s_take  = s_axis_tvalid && s_axis_tready;

	iwe_encoder u_enc (
		.req (req_s1),
		.res (enc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s2   <= '0;
		end else begin
			if (s_take) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				cnt_s2 <= enc.count;
			end else if (m_take) begin
				cnt_s2 <= cnt_s2 - iwe_pkg::CNT_W'(1);
			end
		end
	end

	// payload: request register and output word buffer
	always_ff @(posedge clk) begin
		if (s_take) begin
			req_s1.req_type       <= s_axis_tuser;
			req_s1.dest_reg       <= s_axis_tdata[4:0];
			req_s1.first_src_reg  <= s_axis_tdata[9:5];
			req_s1.second_src_reg <= s_axis_tdata[14:10];
			req_s1.cond_code      <= s_axis_tdata[18:15];
			req_s1.imm_value      <= s_axis_tdata[82:19];
			req_s1.byte_offset    <= s_axis_tdata[114:83];
			req_s1.shift_amount   <= s_axis_tdata[120:115];
		end
		if (load_s2) begin
			words_s2 <= enc.words;
		end else if (m_take) begin
			for (int i = 0; i < iwe_pkg::MAX_WORDS - 1; i++) begin
				words_s2[i] <= words_s2[i + 1];
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s2 <= iwe_pkg::CNT_W'(iwe_pkg::MAX_WORDS))
		else $error("word count out of range");

	a_burst_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_take && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("multi-word request lost words");

	a_s1_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && enc.count != '0 && !s2_free) |=> valid_s1)
		else $error("request left input stage while output buffer busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |-> (!m_axis_tvalid || (m_take && m_axis_tlast)))
		else $error("output buffer overwritten");

endmodule

// ===== hw/rtl/iwe_encoder.sv =====
// ----------------------------------------------------------------------------
// iwe_encoder
// Combinational field packing of one request into zero to four words.
// ----------------------------------------------------------------------------
module iwe_encoder (
	input  iwe_pkg::req_t req,
	output iwe_pkg::enc_t res
);

	logic [31:0] rd, rn, rm, rn16, rm16, rm10, cc, cc12;
	logic [31:0] imm12_f;
	logic [31:0] hw_f;
	logic [31:0] biased;
	logic [31:0] ldr_f, pair_f;
	logic [31:0] br26_f, br19_f;
	logic [31:0] adrp_f;
	logic [5:0]  immr, imms;
	logic [63:0] imm;

	assign imm  = req.imm_value;
	assign rd   = 32'(req.dest_reg);
	assign rn   = 32'(req.first_src_reg) << 5;
	assign rn16 = 32'(req.first_src_reg) << 16;
	assign rm   = 32'(req.second_src_reg);
	assign rm16 = rm << 16;
	assign rm10 = rm << 10;
	assign cc   = 32'(req.cond_code);
	assign cc12 = cc << 12;

	assign imm12_f = 32'(imm[11:0]) << 10;
	assign hw_f    = 32'(req.shift_amount[5:4]) << 21;

	// signed divide by 8 rounding toward zero: bias negatives by 7
	assign biased = req.byte_offset + {29'b0, {3{req.byte_offset[31]}}};
	assign ldr_f  = 32'(biased[14:3]) << 10;
	assign pair_f = 32'(biased[9:3]) << 15;

	assign br26_f = 32'(req.byte_offset[27:2]);
	assign br19_f = 32'(req.byte_offset[20:2]) << 5;
	assign adrp_f = (32'(req.byte_offset[1:0]) << 29) | (32'(req.byte_offset[20:2]) << 5);

	assign immr = 6'd0 - req.shift_amount;
	assign imms = ~req.shift_amount;

	always_comb begin
		res          = '0;
		res.count    = 3'd1;
		res.words[0] = '0;
		case (iwe_pkg::op_t'(req.req_type))
			iwe_pkg::OP_MOV_RR: begin
				if (req.dest_reg == req.first_src_reg) begin
					res.count = 3'd0;
				end else if (req.dest_reg == iwe_pkg::REG_SP
						|| req.first_src_reg == iwe_pkg::REG_SP) begin
					res.words[0] = iwe_pkg::ENC_ADD_IMM | rn | rd;
				end else begin
					res.words[0] = iwe_pkg::ENC_MOV_REG | rn16 | rd;
				end
			end
			iwe_pkg::OP_MOVZ:
				res.words[0] = iwe_pkg::ENC_MOVZ | hw_f | (32'(imm[15:0]) << 5) | rd;
			iwe_pkg::OP_MOVK:
				res.words[0] = iwe_pkg::ENC_MOVK | hw_f | (32'(imm[15:0]) << 5) | rd;
			iwe_pkg::OP_MOV_IMM: begin
				res.words[0] = iwe_pkg::ENC_MOVZ | (32'(imm[15:0]) << 5) | rd;
				res.words[1] = iwe_pkg::ENC_MOVK | (32'd1 << 21) | (32'(imm[31:16]) << 5) | rd;
				res.words[2] = iwe_pkg::ENC_MOVK | (32'd2 << 21) | (32'(imm[47:32]) << 5) | rd;
				res.words[3] = iwe_pkg::ENC_MOVK | (32'd3 << 21) | (32'(imm[63:48]) << 5) | rd;
				if (imm[63:48] != '0) begin
					res.count = 3'd4;
				end else if (imm[47:32] != '0) begin
					res.count = 3'd3;
				end else if (imm[31:16] != '0) begin
					res.count = 3'd2;
				end
			end
			iwe_pkg::OP_LDR:    res.words[0] = iwe_pkg::ENC_LDR | ldr_f | rn | rd;
			iwe_pkg::OP_STR:    res.words[0] = iwe_pkg::ENC_STR | ldr_f | rn | rd;
			iwe_pkg::OP_ADD_RRR: res.words[0] = iwe_pkg::ENC_ADD_REG | rm16 | rn | rd;
			iwe_pkg::OP_ADD_RRI: res.words[0] = iwe_pkg::ENC_ADD_IMM | imm12_f | rn | rd;
			iwe_pkg::OP_SUB_RRR: res.words[0] = iwe_pkg::ENC_SUB_REG | rm16 | rn | rd;
			iwe_pkg::OP_SUB_RRI: res.words[0] = iwe_pkg::ENC_SUB_IMM | imm12_f | rn | rd;
			iwe_pkg::OP_MUL:    res.words[0] = iwe_pkg::ENC_MUL | rm16 | rn | rd;
			iwe_pkg::OP_SDIV:   res.words[0] = iwe_pkg::ENC_SDIV | rm16 | rn | rd;
			iwe_pkg::OP_NEG:    res.words[0] = iwe_pkg::ENC_NEG | rn16 | rd;
			iwe_pkg::OP_AND:    res.words[0] = iwe_pkg::ENC_AND | rm16 | rn | rd;
			iwe_pkg::OP_ORR:    res.words[0] = iwe_pkg::ENC_ORR | rm16 | rn | rd;
			iwe_pkg::OP_EOR:    res.words[0] = iwe_pkg::ENC_EOR | rm16 | rn | rd;
			iwe_pkg::OP_MVN:    res.words[0] = iwe_pkg::ENC_MVN | rn16 | rd;
			iwe_pkg::OP_LSL:
				res.words[0] = iwe_pkg::ENC_UBFM | (32'(immr) << 16) | (32'(imms) << 10)
					| rn | rd;
			iwe_pkg::OP_LSR:
				res.words[0] = iwe_pkg::ENC_LSR | (32'(req.shift_amount) << 16) | rn | rd;
			iwe_pkg::OP_CMP_RR: res.words[0] = iwe_pkg::ENC_CMP_REG | rm16 | rn;
			iwe_pkg::OP_CMP_RI: res.words[0] = iwe_pkg::ENC_CMP_IMM | imm12_f | rn;
			iwe_pkg::OP_TST:    res.words[0] = iwe_pkg::ENC_TST | rm16 | rn;
			iwe_pkg::OP_CSEL:   res.words[0] = iwe_pkg::ENC_CSEL | rm16 | cc12 | rn | rd;
			iwe_pkg::OP_CSET:   res.words[0] = iwe_pkg::ENC_CSET | ((cc ^ 32'd1) << 12) | rd;
			iwe_pkg::OP_STP:    res.words[0] = iwe_pkg::ENC_STP | pair_f | rm10 | rn | rd;
			iwe_pkg::OP_LDP:    res.words[0] = iwe_pkg::ENC_LDP | pair_f | rm10 | rn | rd;
			iwe_pkg::OP_B:      res.words[0] = iwe_pkg::ENC_B | br26_f;
			iwe_pkg::OP_B_COND: res.words[0] = iwe_pkg::ENC_B_COND | br19_f | cc;
			iwe_pkg::OP_BL:     res.words[0] = iwe_pkg::ENC_BL | br26_f;
			iwe_pkg::OP_BR:     res.words[0] = iwe_pkg::ENC_BR | (rd << 5);
			iwe_pkg::OP_BLR:    res.words[0] = iwe_pkg::ENC_BLR | (rd << 5);
			iwe_pkg::OP_RET:    res.words[0] = iwe_pkg::ENC_RET | (rd << 5);
			iwe_pkg::OP_FMOV:   res.words[0] = iwe_pkg::ENC_FMOV | rn | rd;
			iwe_pkg::OP_FADD:   res.words[0] = iwe_pkg::ENC_FADD | rm16 | rn | rd;
			iwe_pkg::OP_FSUB:   res.words[0] = iwe_pkg::ENC_FSUB | rm16 | rn | rd;
			iwe_pkg::OP_FMUL:   res.words[0] = iwe_pkg::ENC_FMUL | rm16 | rn | rd;
			iwe_pkg::OP_FDIV:   res.words[0] = iwe_pkg::ENC_FDIV | rm16 | rn | rd;
			iwe_pkg::OP_SCVTF:  res.words[0] = iwe_pkg::ENC_SCVTF | rn | rd;
			iwe_pkg::OP_FCVTZS: res.words[0] = iwe_pkg::ENC_FCVTZS | rn | rd;
			iwe_pkg::OP_ADRP:   res.words[0] = iwe_pkg::ENC_ADRP | adrp_f | rd;
			default:            res.count = 3'd0;
		endcase
	end

endmodule
